[sv/flagged_channel_averager_assert.svh]
// Assertion macros for the flagged channel averager.
`ifndef FLAGGED_CHANNEL_AVERAGER_ASSERT_SVH
`define FLAGGED_CHANNEL_AVERAGER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FCA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define FCA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/fca_pkg.sv]
// Shared types and constants of the flagged channel averager.
package fca_pkg;

	localparam int unsigned CORR_W   = 24;
	localparam int unsigned N_PARTS  = 8;
	localparam int unsigned FREQ_W   = 40;
	localparam int unsigned MARK_W   = 2;
	localparam int unsigned S_DATA_W = 240;
	localparam int unsigned M_DATA_W = 232;

	localparam logic [MARK_W-1:0] MARK_WITHIN = 2'd0;

	localparam logic KIND_ROW  = 1'b0;
	localparam logic KIND_FREQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DIV,
		ST_ROW,
		ST_FREQ
	} fca_state_t;

	// per-beat control shared by all lanes
	typedef struct packed {
		logic add;   // add this sample to the row sum
		logic fin;   // row ends on this beat: start the divide, clear the sum
	} fca_lane_ctl_t;

endpackage

[sv/fca_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module fca_div #(
	parameter int unsigned NUM_W = 35,
	parameter int unsigned DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quot,
	output logic             done
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;

	assign rem_sh = {rem_q, quot_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NUM_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (cnt_q != '0) begin
			if (!diff[DEN_W]) begin
				rem_q  <= diff[DEN_W-1:0];
				quot_q <= {quot_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[DEN_W-1:0];
				quot_q <= {quot_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

[sv/fca_lane.sv]
// One correlation part: row accumulator and signed mean via serial divide.
module fca_lane #(
	parameter int unsigned CNT_W = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fca_pkg::fca_lane_ctl_t       ctl,
	input  logic [fca_pkg::CORR_W-1:0]   sample,
	input  logic [CNT_W-1:0]             count,
	output logic [fca_pkg::CORR_W-1:0]   avg,
	output logic                         done
);

	localparam int unsigned SUM_W = fca_pkg::CORR_W + CNT_W;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_total;
	logic [SUM_W-1:0] mag;
	logic             neg_q;
	logic [SUM_W-1:0] quot;
	logic [fca_pkg::CORR_W-1:0] q_low;

	assign sum_total = ctl.add
		? sum_q + {{(SUM_W-fca_pkg::CORR_W){sample[fca_pkg::CORR_W-1]}}, sample}
		: sum_q;
	assign mag = sum_total[SUM_W-1] ? (~sum_total + 1'b1) : sum_total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.fin) begin
			sum_q <= '0;
		end else if (ctl.add) begin
			sum_q <= sum_total;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			neg_q <= sum_total[SUM_W-1];
		end
	end

	fca_div #(
		.NUM_W(SUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (ctl.fin),
		.num   (mag),
		.den   (count),
		.quot  (quot),
		.done  (done)
	);

	// truncation toward zero: divide magnitudes, restore the sign
	assign q_low = quot[fca_pkg::CORR_W-1:0];
	assign avg   = neg_q ? (~q_low + 1'b1) : q_low;

endmodule

[sv/flagged_channel_averager.sv]
// Top level of the flagged channel averager: lanes, frequency mean, result merge.
//
//  channel | dir | tdata (low bit up)                            | tuser / tlast
//  s_      | in  | corr0_re..corr3_im, chan_freq, end_marker     | chan_flagged, row_flagged
//  m_      | out | avg0_re..avg3_im, mean_freq                   | result_kind, row_flag_out / last_out
//
// Samples within a row are taken back to back while s_tready is high. A row end stalls
// input while the eight lane dividers run; a buffer end also waits on the frequency
// divider. Each result beat then waits for m_tready; input is held off until all are taken.
// Reset clears all sums and counts.
module flagged_channel_averager #(
	parameter int unsigned MAX_CHANNELS = 1024,
	parameter int unsigned MAX_ROWS     = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fca_pkg::S_DATA_W-1:0]   s_tdata,  // corr0_re..corr3_im, chan_freq, end_marker
	input  logic [1:0]                     s_tuser,  // chan_flagged, row_flagged
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fca_pkg::M_DATA_W-1:0]   m_tdata,  // avg0_re..avg3_im, mean_freq
	output logic [1:0]                     m_tuser,  // result_kind, row_flag_out
	output logic                           m_tlast
);

	`include "flagged_channel_averager_assert.svh"

	localparam int unsigned CNT_W    = $clog2(MAX_CHANNELS + 1);
	localparam longint unsigned FCAP = longint'(MAX_CHANNELS) * longint'(MAX_ROWS);
	localparam int unsigned FCNT_W   = $clog2(FCAP + 1);
	localparam int unsigned FSUM_W   = fca_pkg::FREQ_W + FCNT_W;
	localparam int unsigned CORRS_W  = fca_pkg::CORR_W * fca_pkg::N_PARTS;
	localparam int unsigned FREQ_LO  = CORRS_W;
	localparam int unsigned MARK_LO  = CORRS_W + fca_pkg::FREQ_W;

	fca_pkg::fca_state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [FCNT_W-1:0] fcnt_q;
	logic [FSUM_W-1:0] fsum_q;
	logic              acc;
	logic              use_s;
	logic              add_row;
	logic              add_f;
	logic              fin;
	logic [fca_pkg::MARK_W-1:0] marker;
	logic [CNT_W-1:0]  cnt_total;
	logic [FCNT_W-1:0] fcnt_total;
	logic [FSUM_W-1:0] fsum_total;
	logic              rowflag_q;
	logic              bufend_q;
	logic              fzero_q;
	logic              fdone;
	logic [FSUM_W-1:0] fquot;
	logic [fca_pkg::N_PARTS-1:0] lane_done;
	logic [fca_pkg::CORR_W-1:0]  lane_avg [fca_pkg::N_PARTS];
	fca_pkg::fca_lane_ctl_t      ctl;
	logic              div_ready;
	logic [fca_pkg::M_DATA_W-1:0]  row_data;
	logic [fca_pkg::M_DATA_W-1:0]  freq_data;

	logic                          vld_q;
	logic [fca_pkg::M_DATA_W-1:0]  data_q;
	logic [1:0]                    user_q;
	logic                          last_q;

	assign s_tready = (state_q == fca_pkg::ST_ACC);
	assign acc      = s_tvalid && s_tready;
	assign marker   = s_tdata[MARK_LO +: fca_pkg::MARK_W];
	assign use_s    = !s_tuser[0] && !s_tuser[1];
	assign add_row  = acc && use_s && (cnt_q < CNT_W'(MAX_CHANNELS));
	assign add_f    = acc && use_s && (fcnt_q < FCNT_W'(FCAP));
	assign fin      = acc && (marker != fca_pkg::MARK_WITHIN);
	assign ctl      = '{add: add_row, fin: fin};

	assign cnt_total  = cnt_q + CNT_W'(add_row);
	assign fcnt_total = fcnt_q + FCNT_W'(add_f);
	assign fsum_total = add_f
		? fsum_q + {{(FSUM_W-fca_pkg::FREQ_W){1'b0}}, s_tdata[FREQ_LO +: fca_pkg::FREQ_W]}
		: fsum_q;

	for (genvar g = 0; g < fca_pkg::N_PARTS; g++) begin : g_lane
		fca_lane #(
			.CNT_W(CNT_W)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.sample(s_tdata[g*fca_pkg::CORR_W +: fca_pkg::CORR_W]),
			.count (cnt_total),
			.avg   (lane_avg[g]),
			.done  (lane_done[g])
		);
	end

	fca_div #(
		.NUM_W(FSUM_W),
		.DEN_W(FCNT_W)
	) u_fdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (fin && marker[1]),
		.num   (fsum_total),
		.den   (fcnt_total),
		.quot  (fquot),
		.done  (fdone)
	);

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fcnt_q <= '0;
			fsum_q <= '0;
		end else if (acc) begin
			cnt_q <= fin ? '0 : cnt_total;
			if (fin && marker[1]) begin
				fcnt_q <= '0;
				fsum_q <= '0;
			end else begin
				fcnt_q <= fcnt_total;
				fsum_q <= fsum_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			rowflag_q <= s_tuser[1] || (cnt_total == '0);
			bufend_q  <= marker[1];
			fzero_q   <= (fcnt_total == '0);
		end
	end

	assign div_ready = (&lane_done) && (!bufend_q || fdone);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fca_pkg::ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fca_pkg::ST_ACC:  if (fin) state_d = fca_pkg::ST_DIV;
			fca_pkg::ST_DIV:  if (div_ready) state_d = fca_pkg::ST_ROW;
			fca_pkg::ST_ROW:  if (m_tready) begin
				state_d = bufend_q ? fca_pkg::ST_FREQ : fca_pkg::ST_ACC;
			end
			fca_pkg::ST_FREQ: if (m_tready) state_d = fca_pkg::ST_ACC;
			default:          state_d = fca_pkg::ST_ACC;
		endcase
	end

	// flagged or empty rows give zero data
	for (genvar g = 0; g < fca_pkg::N_PARTS; g++) begin : g_row_data
		assign row_data[g*fca_pkg::CORR_W +: fca_pkg::CORR_W] =
			rowflag_q ? {fca_pkg::CORR_W{1'b0}} : lane_avg[g];
	end
	assign row_data[FREQ_LO +: fca_pkg::FREQ_W] = {fca_pkg::FREQ_W{1'b0}};

	assign freq_data = {fzero_q ? {fca_pkg::FREQ_W{1'b0}} : fquot[fca_pkg::FREQ_W-1:0],
		{CORRS_W{1'b0}}};

	// merge: output register holding one result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= (state_d == fca_pkg::ST_ROW) || (state_d == fca_pkg::ST_FREQ);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fca_pkg::ST_DIV && div_ready) begin
			data_q <= row_data;
			user_q <= {rowflag_q, fca_pkg::KIND_ROW};
			last_q <= !bufend_q;
		end else if (state_q == fca_pkg::ST_ROW && m_tready) begin
			data_q <= freq_data;
			user_q <= {1'b0, fca_pkg::KIND_FREQ};
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

	`FCA_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
	`FCA_ASSERT_IMP(a_freq_last, m_tvalid && m_tuser[0], m_tlast)
	`FCA_ASSERT_NEXT(a_fin_div, fin, state_q == fca_pkg::ST_DIV)

endmodule
